// ===== hdl/cartridge_bank_switch_mapper_assert.svh =====
// assertion macros for the cartridge bank switch mapper
// used by cbsm_ctrl and cartridge_bank_switch_mapper; no other dependencies
`ifndef CARTRIDGE_BANK_SWITCH_MAPPER_ASSERT_SVH
`define CARTRIDGE_BANK_SWITCH_MAPPER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// check on the clock, disabled while reset is applied
`define CBSM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check on the clock, also while reset is applied
`define CBSM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CBSM_ASSERT(lbl, clk, rst_n, prop, msg)
`define CBSM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hdl/cbsm_pkg.sv =====
// shared constants and types for the cartridge bank switch mapper
// no dependencies
`default_nettype none

package cbsm_pkg;

    // default sizes
    localparam int NUM_BANKS_DEF = 64;
    localparam int RAM_BYTES_DEF = 128;

    // field widths
    localparam int ADDR_W     = 13;
    localparam int OFF_W      = 12;
    localparam int DATA_W     = 8;
    localparam int INDEX_W    = 18;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    // opcodes
    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_MODE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_BANK = 1'b1;

    // address decode
    localparam int                 A12_BIT     = 12;
    localparam logic [OFF_W-1:0]   HOT_FIRST   = 12'hF80;
    localparam logic [OFF_W-1:0]   HOT_LAST    = 12'hFBF;
    localparam logic [ADDR_W-1:0]  PORT_JOY    = 13'h280;
    localparam logic [ADDR_W-1:0]  PORT_SWITCH = 13'h282;

    // bank selected out of reset
    localparam logic [CFG_DATA_W-1:0] STARTUP_BANK_RST = 6'd1;

    // per-request result information carried alongside the memory read
    typedef struct packed {
        logic drive_bus;
        logic src_ram;
        logic exited;
    } t_meta;

endpackage

`default_nettype wire

// ===== hdl/cbsm_ram.sv =====
// generic single-port synchronous ram with registered read
// no dependencies
`default_nettype none

module cbsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write, or read into the output register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/cbsm_ctrl.sv =====
// request decode, bank and port state, configuration registers
// depends on cbsm_pkg and cartridge_bank_switch_mapper_assert.svh
`default_nettype none
`include "cartridge_bank_switch_mapper_assert.svh"

module cbsm_ctrl #(
    parameter int NUM_BANKS = cbsm_pkg::NUM_BANKS_DEF,
    parameter int RAM_BYTES = cbsm_pkg::RAM_BYTES_DEF,
    parameter int BANK_W    = $clog2(NUM_BANKS),
    parameter int IMG_AW    = BANK_W + cbsm_pkg::OFF_W,
    parameter int RAM_AW    = $clog2(RAM_BYTES)
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [cbsm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [cbsm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              i_accept,
    input  wire logic                              i_opcode,
    input  wire logic [cbsm_pkg::ADDR_W-1:0]       i_bus_address,
    input  wire logic [cbsm_pkg::DATA_W-1:0]       i_bus_data,
    input  wire logic [cbsm_pkg::INDEX_W-1:0]      i_image_index,
    output logic                                   o_img_en,
    output logic                                   o_img_we,
    output logic      [IMG_AW-1:0]                 o_img_addr,
    output logic      [cbsm_pkg::DATA_W-1:0]       o_img_wdata,
    output logic                                   o_wram_en,
    output logic                                   o_wram_we,
    output logic      [RAM_AW-1:0]                 o_wram_addr,
    output logic      [cbsm_pkg::DATA_W-1:0]       o_wram_wdata,
    output cbsm_pkg::t_meta                        o_meta
);

    import cbsm_pkg::*;

    logic              r_ram_mode;
    logic [BANK_W-1:0] r_bank;
    logic              r_joy;
    logic              r_exited;
    logic [BANK_W-1:0] n_bank;
    logic              n_joy;
    logic              n_exited;

    logic              access;
    logic              is_load;
    logic [OFF_W-1:0]  off;
    logic [OFF_W-1:0]  hot_diff;
    logic              in_cart;
    logic              hot;
    logic              ram_wr;
    logic              ram_rd;
    logic              rom_rd;
    logic              rd;
    logic [BANK_W-1:0] bank_used;

    // address decode of the current request
    always_comb begin
        is_load   = (i_opcode == OP_LOAD);
        access    = !is_load && !r_exited;
        off       = i_bus_address[OFF_W-1:0];
        hot_diff  = off - HOT_FIRST;
        in_cart   = access && i_bus_address[A12_BIT];
        hot       = (off >= HOT_FIRST) && (off <= HOT_LAST);
        ram_wr    = in_cart && r_ram_mode && (off < OFF_W'(RAM_BYTES));
        rd        = in_cart && !ram_wr;
        ram_rd    = rd && r_ram_mode && (off < OFF_W'(2 * RAM_BYTES));
        rom_rd    = rd && !ram_rd;
        n_bank    = (rd && hot) ? hot_diff[BANK_W-1:0] : r_bank;
        bank_used = n_bank;
        n_joy     = r_joy;
        n_exited  = r_exited;
        if (access && (i_bus_address == PORT_JOY)) begin
            n_joy = !i_bus_data[DATA_W-1];
        end
        if (access && (i_bus_address == PORT_SWITCH) && !i_bus_data[0] && r_joy) begin
            n_exited = 1'b1;
        end
    end

    // memory requests
    always_comb begin
        o_img_en     = i_accept && (is_load || rom_rd);
        o_img_we     = is_load;
        o_img_addr   = is_load ? i_image_index[IMG_AW-1:0] : {bank_used, off};
        o_img_wdata  = i_bus_data;
        o_wram_en    = i_accept && (ram_wr || ram_rd);
        o_wram_we    = ram_wr;
        o_wram_addr  = off[RAM_AW-1:0];
        o_wram_wdata = i_bus_data;
        o_meta.drive_bus = rd;
        o_meta.src_ram   = ram_rd;
        o_meta.exited    = n_exited;
    end

    // configuration and mapper state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_mode <= 1'b0;
            r_bank     <= STARTUP_BANK_RST[BANK_W-1:0];
            r_joy      <= 1'b0;
            r_exited   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RAM_MODE:     r_ram_mode <= i_cfg_data[0];
                CFG_STARTUP_BANK: r_bank     <= i_cfg_data[BANK_W-1:0];
                default:          r_ram_mode <= r_ram_mode;
            endcase
        end else if (i_accept) begin
            r_bank   <= n_bank;
            r_joy    <= n_joy;
            r_exited <= n_exited;
        end
    end

    `CBSM_ASSERT(a_exit_sticky, i_clk, i_rst_n, r_exited |=> r_exited, "exit flag cleared")
    `CBSM_ASSERT(a_one_mem, i_clk, i_rst_n, !(o_img_en && o_wram_en), "both memories used")
    `CBSM_ASSERT(a_no_access_after_exit, i_clk, i_rst_n, r_exited |-> !o_wram_en, "ram used after exit")

endmodule

`default_nettype wire

// ===== hdl/cartridge_bank_switch_mapper.sv =====
// Cartridge bank switch mapper. One request is taken per clock while o_in_stall is
// low; each gives one result after one read of the image or work memory and the
// output register. The single port of each memory sets this: a request loads an
// image byte, reads one image byte, or writes or reads one work ram byte, in the
// cycle it is accepted. The memory stage and the output register hold two requests
// between them, so a waiting result costs nothing until the memory stage is full
// as well; only then is the input stalled, in the same cycle as i_out_stall.
// Memories start undefined and need no clearing pass after reset. Configuration
// writes must be made only while the block is idle; the block does not enforce it.
// depends on cbsm_pkg, cbsm_ram, cbsm_ctrl and cartridge_bank_switch_mapper_assert.svh
`default_nettype none
`include "cartridge_bank_switch_mapper_assert.svh"

module cartridge_bank_switch_mapper #(
    parameter int NUM_BANKS = cbsm_pkg::NUM_BANKS_DEF,
    parameter int RAM_BYTES = cbsm_pkg::RAM_BYTES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [cbsm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [cbsm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_opcode,
    input  wire logic [cbsm_pkg::ADDR_W-1:0]     i_bus_address,
    input  wire logic [cbsm_pkg::DATA_W-1:0]     i_bus_data,
    input  wire logic [cbsm_pkg::INDEX_W-1:0]    i_image_index,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic                                 o_drive_bus,
    output logic      [cbsm_pkg::DATA_W-1:0]     o_read_data,
    output logic                                 o_exit_request
);

    import cbsm_pkg::*;

    localparam int BANK_W = $clog2(NUM_BANKS);
    localparam int IMG_AW = BANK_W + OFF_W;
    localparam int RAM_AW = $clog2(RAM_BYTES);

    logic              accept;
    logic              s1_adv;
    logic              img_en;
    logic              img_we;
    logic [IMG_AW-1:0] img_addr;
    logic [DATA_W-1:0] img_wdata;
    logic [DATA_W-1:0] img_q;
    logic              wram_en;
    logic              wram_we;
    logic [RAM_AW-1:0] wram_addr;
    logic [DATA_W-1:0] wram_wdata;
    logic [DATA_W-1:0] wram_q;
    t_meta             meta;

    logic              r_s1_valid;
    logic              n_s1_valid;
    t_meta             r_s1_meta;
    logic              r_out_valid;
    logic              r_out_drive;
    logic [DATA_W-1:0] r_out_data;
    logic              r_out_exit;

    // handshake: a request enters when the memory stage is empty or moving on
    assign s1_adv     = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign accept     = i_in_valid && !o_in_stall;

    cbsm_ctrl #(
        .NUM_BANKS (NUM_BANKS),
        .RAM_BYTES (RAM_BYTES),
        .BANK_W    (BANK_W),
        .IMG_AW    (IMG_AW),
        .RAM_AW    (RAM_AW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_opcode      (i_opcode),
        .i_bus_address (i_bus_address),
        .i_bus_data    (i_bus_data),
        .i_image_index (i_image_index),
        .o_img_en      (img_en),
        .o_img_we      (img_we),
        .o_img_addr    (img_addr),
        .o_img_wdata   (img_wdata),
        .o_wram_en     (wram_en),
        .o_wram_we     (wram_we),
        .o_wram_addr   (wram_addr),
        .o_wram_wdata  (wram_wdata),
        .o_meta        (meta)
    );

    // cartridge image memory
    cbsm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_BANKS * (2 ** OFF_W))
    ) u_image_ram (
        .i_clk   (i_clk),
        .i_en    (img_en),
        .i_we    (img_we),
        .i_addr  (img_addr),
        .i_wdata (img_wdata),
        .o_rdata (img_q)
    );

    // work ram
    cbsm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_BYTES)
    ) u_work_ram (
        .i_clk   (i_clk),
        .i_en    (wram_en),
        .i_we    (wram_we),
        .i_addr  (wram_addr),
        .i_wdata (wram_wdata),
        .o_rdata (wram_q)
    );

    // memory stage occupancy
    always_comb begin
        if (accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_meta <= meta;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out_drive <= r_s1_meta.drive_bus;
            r_out_exit  <= r_s1_meta.exited;
            if (!r_s1_meta.drive_bus) begin
                r_out_data <= '0;
            end else if (r_s1_meta.src_ram) begin
                r_out_data <= wram_q;
            end else begin
                r_out_data <= img_q;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_drive_bus    = r_out_drive;
    assign o_read_data    = r_out_data;
    assign o_exit_request = r_out_exit;

    `CBSM_ASSERT(a_idle_data_zero, i_clk, i_rst_n,
        (r_out_valid && !r_out_drive) |-> (r_out_data == '0), "undriven result not zero")
    `CBSM_ASSERT(a_stall_full, i_clk, i_rst_n,
        o_in_stall |-> (r_s1_valid && r_out_valid), "stall with free stage")
    `CBSM_ASSERT(a_s1_hold, i_clk, i_rst_n,
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_meta)),
        "memory stage lost its request")
    `CBSM_ASSERT_ALWAYS(a_reset_empty, i_clk,
        !i_rst_n |=> (!r_s1_valid && !r_out_valid), "pipeline not empty after reset")

endmodule

`default_nettype wire

// ===== tb/sv/cartridge_bank_switch_mapper_tb.sv =====
// self-checking testbench for cartridge_bank_switch_mapper: bank reads, hotspots, ram window,
// joystick and switch ports, exit; predicts every result and compares it field by field
// depends on cbsm_pkg and the cartridge_bank_switch_mapper rtl
import cbsm_pkg::*;

localparam int unsigned BANK_BYTES  = 32'h1000;
localparam int unsigned IMAGE_BYTES = NUM_BANKS_DEF * BANK_BYTES;
localparam logic [ADDR_W-1:0] BANK_AREA     = 13'h1000;
localparam logic [OFF_W-1:0]  RAM_READ_BASE = 12'h080;
localparam logic [OFF_W-1:0]  RAM_WIN_END   = 12'h100;

// mirror of the mapper state plus the queue of results still owed
class mapper_scoreboard;
    typedef struct {
        logic              drive;
        logic [DATA_W-1:0] data;
        logic              exit_flag;
    } reply_t;

    bit                ram_mode;
    bit [5:0]          cur_bank;
    bit                joy_held;
    bit                exited;
    bit [DATA_W-1:0]   image [IMAGE_BYTES];
    bit                image_set [IMAGE_BYTES];
    bit [DATA_W-1:0]   work_ram [RAM_BYTES_DEF];
    bit                ram_set [RAM_BYTES_DEF];
    reply_t            replies_due [$];
    int                errors;

    function new();
        ram_mode = 1'b0;
        cur_bank = STARTUP_BANK_RST;
        joy_held = 1'b0;
        exited   = 1'b0;
        errors   = 0;
    endfunction

    function void set_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        if (idx == CFG_RAM_MODE) begin
            ram_mode = val[0];
        end else begin
            // startup bank takes effect at once
            cur_bank = val;
        end
    endfunction

    // location a console access would read, if it reads memory at all
    function bit read_target(logic [ADDR_W-1:0] addr, output bit from_ram,
                             output int unsigned loc);
        logic [OFF_W-1:0] off;
        logic [5:0]       bank;
        off      = addr[OFF_W-1:0];
        bank     = cur_bank;
        from_ram = 1'b0;
        loc      = 0;
        if (exited || !addr[A12_BIT]) return 1'b0;
        if (ram_mode && off < RAM_READ_BASE) return 1'b0;
        if (off >= HOT_FIRST && off <= HOT_LAST) bank = 6'(off - HOT_FIRST);
        if (ram_mode && off < RAM_WIN_END) begin
            from_ram = 1'b1;
            loc      = off[6:0];
        end else begin
            loc = {bank, off};
        end
        return 1'b1;
    endfunction

    // apply one accepted request and queue the result it owes
    function void note_request(logic op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data,
                               logic [INDEX_W-1:0] idx);
        reply_t           r;
        bit               from_ram;
        int unsigned      loc;
        logic [OFF_W-1:0] off;
        r.drive = 1'b0;
        r.data  = '0;
        off     = addr[OFF_W-1:0];
        if (op == OP_LOAD) begin
            image[idx]     = data;
            image_set[idx] = 1'b1;
        end else if (!exited) begin
            if (addr[A12_BIT]) begin
                if (ram_mode && off < RAM_READ_BASE) begin
                    work_ram[off[6:0]] = data;
                    ram_set[off[6:0]]  = 1'b1;
                end else begin
                    void'(read_target(addr, from_ram, loc));
                    if (off >= HOT_FIRST && off <= HOT_LAST) cur_bank = 6'(off - HOT_FIRST);
                    r.drive = 1'b1;
                    r.data  = from_ram ? work_ram[loc] : image[loc];
                end
            end else if (addr == PORT_JOY) begin
                joy_held = !data[7];
            end else if (addr == PORT_SWITCH && !data[0] && joy_held) begin
                exited = 1'b1;
            end
        end
        r.exit_flag = exited;
        replies_due.push_back(r);
    endfunction

    function void check_reply(logic drive, logic [DATA_W-1:0] data, logic exit_flag);
        reply_t e;
        if (replies_due.size() == 0) begin
            $error("unexpected result: drive_bus %0b read_data %02h exit_request %0b",
                   drive, data, exit_flag);
            errors++;
            return;
        end
        e = replies_due.pop_front();
        if (drive !== e.drive) begin
            $error("drive_bus: expected %0b, got %0b", e.drive, drive);
            errors++;
        end
        if (data !== e.data) begin
            $error("read_data: expected %02h, got %02h", e.data, data);
            errors++;
        end
        if (exit_flag !== e.exit_flag) begin
            $error("exit_request: expected %0b, got %0b", e.exit_flag, exit_flag);
            errors++;
        end
    endfunction
endclass

module cartridge_bank_switch_mapper_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 500;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  opcode    = OP_ACCESS;
    logic [ADDR_W-1:0]     bus_addr  = '0;
    logic [DATA_W-1:0]     bus_data  = '0;
    logic [INDEX_W-1:0]    image_idx = '0;
    logic                  out_stall = 1'b0;
    wire                   o_in_stall;
    wire                   o_out_valid;
    wire                   o_drive_bus;
    wire  [DATA_W-1:0]     o_read_data;
    wire                   o_exit_request;

    mapper_scoreboard sb = new();

    int               sent          = 0;
    int               out_hold_left = 0;
    int               idle_cycles   = 0;
    bit               in_burst      = 1'b0;
    bit               out_burst     = 1'b0;
    bit               exit_ok       = 1'b0;
    logic [OFF_W-1:0] bank_offs [NUM_BANKS_DEF][$];

    cartridge_bank_switch_mapper u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (opcode),
        .i_bus_address  (bus_addr),
        .i_bus_data     (bus_data),
        .i_image_index  (image_idx),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_drive_bus    (o_drive_bus),
        .o_read_data    (o_read_data),
        .o_exit_request (o_exit_request)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: check each accepted result, then hold off the next one for a while
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall) begin
            sb.check_reply(o_drive_bus, o_read_data, o_exit_request);
            out_hold_left = out_burst ? 0 : $urandom_range(0, 10);
        end
        if (out_hold_left > 0) begin
            out_hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // watchdog on cycles with no traffic on either side
    always @(posedge i_clk) begin
        if ((in_valid && o_in_stall === 1'b0) || (o_out_valid && !out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("cartridge_bank_switch_mapper_tb failed");
            $finish;
        end
    end

    // present one request, wait for it to be taken, then maybe idle
    task automatic send_request(logic op, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d,
                                logic [INDEX_W-1:0] ix);
        int gap;
        opcode    <= op;
        bus_addr  <= a;
        bus_data  <= d;
        image_idx <= ix;
        in_valid  <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        sb.note_request(op, a, d, ix);
        sent++;
        gap = in_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_load(logic [INDEX_W-1:0] ix, logic [DATA_W-1:0] d);
        if (!sb.image_set[ix]) bank_offs[ix[INDEX_W-1:OFF_W]].push_back(ix[OFF_W-1:0]);
        send_request(OP_LOAD, ADDR_W'($urandom), d, ix);
    endtask

    // console access; first fills whatever byte it would read if still unwritten
    task automatic send_access(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
        bit          from_ram;
        int unsigned loc;
        if (sb.read_target(a, from_ram, loc)) begin
            if (from_ram && !sb.ram_set[loc]) begin
                send_request(OP_ACCESS, BANK_AREA | ADDR_W'(loc), DATA_W'($urandom),
                             INDEX_W'($urandom));
            end else if (!from_ram && !sb.image_set[loc]) begin
                send_load(INDEX_W'(loc), DATA_W'($urandom));
            end
        end
        // keep the exit switch released until the last phase
        if (!exit_ok && a == PORT_SWITCH && sb.joy_held) d[0] = 1'b1;
        send_request(OP_ACCESS, a, d, INDEX_W'($urandom));
    endtask

    task automatic random_item();
        int unsigned       pick;
        int unsigned       n;
        logic [ADDR_W-1:0] a;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            send_load(INDEX_W'($urandom), DATA_W'($urandom));
        end else if (pick < 30) begin
            send_load({sb.cur_bank, OFF_W'($urandom)}, DATA_W'($urandom));
        end else if (pick < 55) begin
            // mostly reads of bytes already loaded in the current bank
            n = bank_offs[sb.cur_bank].size();
            if (n > 0) a = BANK_AREA | {1'b0, bank_offs[sb.cur_bank][$urandom_range(0, n - 1)]};
            else a = BANK_AREA | ADDR_W'($urandom_range(0, 4095));
            send_access(a, DATA_W'($urandom));
        end else if (pick < 63) begin
            send_access(BANK_AREA | ADDR_W'(HOT_FIRST + $urandom_range(0, 63)), DATA_W'($urandom));
        end else if (pick < 73) begin
            send_access(BANK_AREA | ADDR_W'($urandom_range(0, 255)), DATA_W'($urandom));
        end else if (pick < 78) begin
            send_access(BANK_AREA | ADDR_W'($urandom_range(0, 4095)), DATA_W'($urandom));
        end else if (pick < 86) begin
            send_access(PORT_JOY, DATA_W'($urandom));
        end else if (pick < 94) begin
            send_access(PORT_SWITCH, DATA_W'($urandom));
        end else begin
            send_access(ADDR_W'($urandom_range(0, 4095)), DATA_W'($urandom));
        end
    endtask

    task automatic run_random(int count);
        int goal;
        int k;
        goal = sent + count;
        k    = 0;
        while (sent < goal) begin
            // switch between idling and back-to-back stretches now and then
            if (k % 80 == 0) begin
                in_burst  = ($urandom_range(0, 3) == 0);
                out_burst = ($urandom_range(0, 3) == 0);
            end
            random_item();
            k++;
        end
    endtask

    // stop sending and wait until every result is back and the pipeline is empty
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.replies_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        sb.set_config(idx, val);
    endtask

    task automatic configure(bit mode, logic [5:0] bank);
        settle();
        write_reg(CFG_RAM_MODE, {5'($urandom), mode});
        write_reg(CFG_STARTUP_BANK, bank);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset bank, bank extremes, hotspots, ports without exit
        send_load(18'h01000, 8'hA5);
        send_access(13'h1000, 8'h00);
        send_load(18'h3FFFF, 8'hFF);
        send_load(18'h3FFBF, 8'h3C);
        send_access(13'h1FBF, 8'hFF);
        send_access(13'h1FFF, 8'h55);
        send_load(18'h00F80, 8'h00);
        send_access(13'h1F80, 8'hAA);
        send_access(PORT_JOY, 8'h80);
        send_access(PORT_SWITCH, 8'h00);
        send_access(PORT_JOY, 8'h7F);
        send_access(PORT_SWITCH, 8'h01);
        send_access(13'h0281, 8'h00);
        send_access(13'h0FFF, 8'hFF);
        send_access(13'h0000, 8'h00);
        send_access(PORT_JOY, 8'hFF);

        // directed: ram window edges, the first bank byte above it and a hotspot read
        configure(1'b1, 6'd15);
        send_access(13'h1000, 8'h5A);
        send_access(13'h107F, 8'hC3);
        send_access(13'h1080, 8'h00);
        send_access(13'h10FF, 8'h00);
        send_load(18'h0F100, 8'h11);
        send_access(13'h1100, 8'h00);
        send_load(18'h0FF8F, 8'h77);
        send_access(13'h1F8F, 8'h00);

        // random phases over several settings, extremes included
        configure(1'b0, 6'd0);
        run_random(260);
        configure(1'b1, 6'd63);
        run_random(260);
        configure(1'b0, 6'd63);
        run_random(260);
        configure(1'b1, 6'd1);
        run_random(260);
        configure(1'b0, 6'($urandom));
        run_random(260);
        configure(1'b1, 6'($urandom));
        run_random(260);

        // last phase: let the exit through, then show later accesses are ignored
        configure(1'($urandom), 6'($urandom));
        run_random(200);
        exit_ok = 1'b1;
        while (!sb.exited) random_item();
        run_random(40);

        settle();
        if (sb.errors == 0 && sb.replies_due.size() == 0) begin
            $display("cartridge_bank_switch_mapper_tb passed");
        end else begin
            $display("cartridge_bank_switch_mapper_tb failed");
        end
        $finish;
    end
endmodule
